@@ sv/ctcgd_pkg.sv @@
`default_nettype none

package ctcgd_pkg;

  // Fixed result field widths
  localparam int unsigned CHAR_W = 13;
  localparam int unsigned SPAN_W = 11;

  // Largest span count that fits the span field
  localparam int unsigned SPAN_FIELD_MAX = 2047;

  // Result kind codes
  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_SPAN = 1'b1
  } kind_t;

  // One queued result
  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_index;
    logic [SPAN_W-1:0] span_frames;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

@@ sv/ctc_greedy_decoder_with_spans_unit.sv @@
`default_nettype none

// Greedy CTC decoder with per-character frame spans. Class scores stream in one
// per transfer, row by row (one row per time frame); the unit keeps the running
// argmax of the row, lowest class winning ties, and at row end applies greedy
// CTC collapse (class 0 is blank, a repeat of the previous frame's winner is
// dropped). Each kept class yields a character result (kind 0); the frames
// between characters yield span results (kind 1), the first span covering the
// leading frames and the final one (last = 1) sent at sequence end. Span counts
// saturate at MAX_FRAMES (capped at 2047 by the field width). Scores beyond
// MAX_CLASSES in a row are ignored; sequence_end closes the frame even without
// row_end. Rate: one score per cycle while in_ready is high. Each transfer is
// resolved in the same cycle against the state registers and its zero to three
// results go into an eight-entry result queue that drains one result per cycle
// while out_ready is high; in_ready drops only while that queue has fewer than
// three free entries, when results arrive faster than the queue drains them.
module ctc_greedy_decoder_with_spans_unit #(
  parameter int unsigned MAX_CLASSES = 8192,
  parameter int unsigned MAX_FRAMES  = 1024,
  parameter int unsigned SCORE_BITS  = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  signed [SCORE_BITS-1:0]  in_score,
  input  wire                           in_row_end,
  input  wire                           in_sequence_end,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_kind,
  output logic [ctcgd_pkg::CHAR_W-1:0]  out_char_index,
  output logic [ctcgd_pkg::SPAN_W-1:0]  out_span_frames,
  output logic                          out_last
);

  import ctcgd_pkg::*;

  localparam int unsigned CW        = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned PW        = $clog2(MAX_CLASSES + 1);
  localparam int unsigned SPAN_LIM  = (MAX_FRAMES > SPAN_FIELD_MAX) ? SPAN_FIELD_MAX
                                                                    : MAX_FRAMES;
  localparam int unsigned QDEPTH    = 8;
  localparam int unsigned QAW       = $clog2(QDEPTH);
  localparam int unsigned QCW       = $clog2(QDEPTH + 1);

  // Row and sequence state
  logic signed [SCORE_BITS-1:0] best_score_r, best_score_nxt;
  logic [CW-1:0]                best_class_r, best_class_nxt;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic [CW-1:0]                prev_r, prev_nxt;
  logic                         first_r, first_nxt;
  logic                         seen_r, seen_nxt;
  logic [SPAN_W-1:0]            span_r, span_nxt;

  // Result queue
  result_t                      queue_r [QDEPTH];
  logic [QAW-1:0]               wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]               rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]               count_r, count_nxt;

  logic                         accept;
  logic                         pop;
  logic                         pos_ok;
  logic                         take;
  logic signed [SCORE_BITS-1:0] row_score;
  logic [CW-1:0]                win;
  logic                         close_frame;
  logic                         keep;
  logic                         span_break;
  logic [SPAN_W-1:0]            span_closed;
  result_t                      res_span, res_char, res_final;
  result_t                      res [3];
  logic [1:0]                   n_res;

  assign in_ready = (count_r <= QCW'(QDEPTH - 3));
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // Running argmax over the row; the first score of a row always wins
  always_comb begin
    pos_ok         = (pos_r < PW'(MAX_CLASSES));
    take           = pos_ok && ((pos_r == '0) || (in_score > best_score_r));
    row_score      = take ? in_score : best_score_r;
    win            = take ? pos_r[CW-1:0] : best_class_r;
    close_frame    = in_row_end || in_sequence_end;
    keep           = (win != '0) && (first_r || (win != prev_r));
    span_break     = keep && seen_r;
    if (span_break) begin
      span_closed = SPAN_W'(1);
    end else if (span_r < SPAN_W'(SPAN_LIM)) begin
      span_closed = span_r + SPAN_W'(1);
    end else begin
      span_closed = span_r;
    end
  end

  // Next state of the decoder
  always_comb begin
    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    pos_nxt        = pos_r;
    prev_nxt       = prev_r;
    first_nxt      = first_r;
    seen_nxt       = seen_r;
    span_nxt       = span_r;
    if (accept) begin
      best_score_nxt = row_score;
      best_class_nxt = win;
      pos_nxt        = pos_ok ? pos_r + PW'(1) : pos_r;
      if (close_frame) begin
        // Start a fresh row
        best_score_nxt = {1'b1, {(SCORE_BITS-1){1'b0}}};
        best_class_nxt = '0;
        pos_nxt        = '0;
        prev_nxt       = win;
        first_nxt      = 1'b0;
        seen_nxt       = seen_r || keep;
        span_nxt       = span_closed;
      end
      if (in_sequence_end) begin
        prev_nxt  = '0;
        first_nxt = 1'b1;
        seen_nxt  = 1'b0;
        span_nxt  = '0;
      end
    end
  end

  // Build this transfer's results in delivery order
  always_comb begin
    res_span.kind         = KIND_SPAN;
    res_span.char_index   = '0;
    res_span.span_frames  = span_r;
    res_span.last         = 1'b0;

    res_char.kind         = KIND_CHAR;
    res_char.char_index   = CHAR_W'(win);
    res_char.span_frames  = '0;
    res_char.last         = 1'b0;

    res_final.kind        = KIND_SPAN;
    res_final.char_index  = '0;
    res_final.span_frames = span_closed;
    res_final.last        = 1'b1;

    // A span break always comes with a kept character
    if (span_break) begin
      res[0] = res_span;
      res[1] = res_char;
    end else if (keep) begin
      res[0] = res_char;
      res[1] = res_final;
    end else begin
      res[0] = res_final;
      res[1] = res_final;
    end
    res[2] = res_final;

    n_res = '0;
    if (accept && close_frame) begin
      n_res = (span_break ? 2'd2 : (keep ? 2'd1 : 2'd0)) + {1'b0, in_sequence_end};
    end
  end

  // Queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(n_res);
    rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + QCW'(n_res) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r <= {1'b1, {(SCORE_BITS-1){1'b0}}};
      best_class_r <= '0;
      pos_r        <= '0;
      prev_r       <= '0;
      first_r      <= 1'b1;
      seen_r       <= 1'b0;
      span_r       <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
      pos_r        <= pos_nxt;
      prev_r       <= prev_nxt;
      first_r      <= first_nxt;
      seen_r       <= seen_nxt;
      span_r       <= span_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      count_r      <= count_nxt;
    end
  end

  // Queue storage: push up to three results at consecutive slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n_res) begin
        queue_r[wr_ptr_r + QAW'(k)] <= res[k];
      end
    end
  end

  // Head of the queue drives the result channel
  assign out_valid       = (count_r != '0);
  assign out_kind        = queue_r[rd_ptr_r].kind;
  assign out_char_index  = queue_r[rd_ptr_r].char_index;
  assign out_span_frames = queue_r[rd_ptr_r].span_frames;
  assign out_last        = queue_r[rd_ptr_r].last;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("result queue overflow");

  a_seq_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_sequence_end |=> first_r && !seen_r && (span_r == '0) && (pos_r == '0))
    else $error("sequence state not cleared after sequence end");

  a_span_sat: assert property (@(posedge clk) disable iff (!rst_n)
    span_r <= SPAN_W'(SPAN_LIM))
    else $error("span count above saturation limit");

  a_seen_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> !first_r)
    else $error("character seen before any frame closed");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

// Testbench for ctc_greedy_decoder_with_spans_unit.
//
// Class scores stream in through a valid/ready channel. A clocked driver pops them from a
// queue that the main initial block fills before reset is released. Every transfer the
// driver makes is run through a software copy of the decoder, which appends the results
// that transfer causes to a queue. A clocked monitor pops that queue on each output
// transfer and compares every field.
//
// Stimulus order:
//   - hand-written frames: score extremes, ties, blanks, repeats, a blank splitting a
//     repeat, and sequence end without row end
//   - random sequences, mostly well formed, some broken on purpose
//
// The sender idles in random bursts and gaps. The receiver stalls on a pattern of its own,
// and at least once it holds off long enough for the result queue to fill and in_ready
// to drop.
module tb;
  import ctcgd_pkg::*;

  localparam int unsigned MAX_CLASSES = 8192;
  localparam int unsigned MAX_FRAMES  = 1024;
  localparam int unsigned SCORE_BITS  = 16;
  // The span field caps the saturation point as well.
  localparam int unsigned SPAN_LIMIT  = (MAX_FRAMES > SPAN_FIELD_MAX) ? SPAN_FIELD_MAX
                                                                     : MAX_FRAMES;
  localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam int unsigned RANDOM_ITEMS = 330;

  // One score waiting to be offered. A set hold_for_drain makes the sender wait until
  // every expected result has come out before it offers this score.
  typedef struct {
    logic [SCORE_BITS-1:0] score;
    bit                    row_end;
    bit                    seq_end;
    bit                    hold_for_drain;
  } score_item_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SLOW
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SCORE_BITS-1:0]  in_score = '0;
  logic                          in_row_end = 1'b0;
  logic                          in_sequence_end = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_kind;
  logic [CHAR_W-1:0]             out_char_index;
  logic [SPAN_W-1:0]             out_span_frames;
  logic                          out_last;

  ctc_greedy_decoder_with_spans_unit #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_FRAMES (MAX_FRAMES),
    .SCORE_BITS (SCORE_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_score       (in_score),
    .in_row_end     (in_row_end),
    .in_sequence_end(in_sequence_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_char_index (out_char_index),
    .out_span_frames(out_span_frames),
    .out_last       (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scores waiting to be offered, and results expected at the output in order.
  score_item_t score_queue[$];
  result_t     decoded_results[$];
  bit          drain_before_next = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned scores_taken = 0;

  // Software decoder state; reset values match the block's reset.
  logic signed [SCORE_BITS-1:0] row_best_score = SCORE_MIN;
  logic [CHAR_W-1:0]            row_best_class = '0;
  int unsigned                  row_position = 0;
  logic [CHAR_W-1:0]            last_winner = '0;
  bit                           at_first_frame = 1'b1;
  bit                           char_seen = 1'b0;
  int unsigned                  frames_in_span = 0;

  // ------------------------------------------------------------------------
  // Decoder prediction
  // ------------------------------------------------------------------------
  function automatic result_t make_result(kind_t kind, logic [CHAR_W-1:0] ch,
                                          int unsigned span, bit last);
    result_t r;
    r.kind        = kind;
    r.char_index  = ch;
    r.span_frames = span[SPAN_W-1:0];
    r.last        = last;
    return r;
  endfunction

  // Append one result to the tail of the expected queue.
  task automatic expect_result(input result_t r);
    decoded_results.insert(decoded_results.size(), r);
  endtask

  task automatic clear_row_state();
    row_best_score = SCORE_MIN;
    row_best_class = '0;
    row_position   = 0;
  endtask

  // Advance the decoder by one transferred score and queue the results it causes.
  task automatic decode_score(input logic signed [SCORE_BITS-1:0] s, input bit row_end,
                              input bit seq_end);
    logic [CHAR_W-1:0] winner;
    bit                kept;
    // Positions at or past MAX_CLASSES are dropped, and the counter stops there.
    if (row_position < MAX_CLASSES) begin
      // The first score of a row always takes the lead; after that, only a strictly
      // greater score does, so the lowest class wins a tie.
      if (row_position == 0 || s > row_best_score) begin
        row_best_score = s;
        row_best_class = row_position[CHAR_W-1:0];
      end
      row_position++;
    end
    // A sequence end closes the frame even without a row end.
    if (row_end || seq_end) begin
      winner = row_best_class;
      // Keep the class unless it is the blank or repeats the last frame's winner.
      kept = (winner != '0) && (at_first_frame || winner != last_winner);
      if (kept && char_seen) begin
        // Close the previous character's span before sending the new character.
        expect_result(make_result(KIND_SPAN, '0, frames_in_span, 1'b0));
        frames_in_span = 1;
      end else begin
        if (frames_in_span < SPAN_LIMIT) frames_in_span++;
        if (kept) char_seen = 1'b1;
      end
      if (kept) expect_result(make_result(KIND_CHAR, winner, 0, 1'b0));
      last_winner    = winner;
      at_first_frame = 1'b0;
      clear_row_state();
      if (seq_end) begin
        expect_result(make_result(KIND_SPAN, '0, frames_in_span, 1'b1));
        last_winner    = '0;
        at_first_frame = 1'b1;
        char_seen      = 1'b0;
        frames_in_span = 0;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Stimulus builders
  // ------------------------------------------------------------------------
  task automatic push_score(input int s, input bit row_end, input bit seq_end);
    score_item_t it;
    it.score          = s[SCORE_BITS-1:0];
    it.row_end        = row_end;
    it.seq_end        = seq_end;
    it.hold_for_drain = drain_before_next;
    drain_before_next = 1'b0;
    score_queue.insert(score_queue.size(), it);
  endtask

  // Add one random sequence. A planned winner gives realistic collapse behavior: repeats,
  // blanks and new characters. A noisy sequence can end in the middle of a row or carry
  // its sequence end without a row end.
  task automatic push_random_sequence(input bit noisy);
    int n_frames;
    int n_classes;
    int winner;
    int prev_winner;
    int style;
    int s;
    bit row_end;
    bit seq_end;
    bit done;
    n_frames    = $urandom_range(1, 10);
    prev_winner = 0;
    done        = 1'b0;
    for (int f = 0; f < n_frames && !done; f++) begin
      n_classes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1, 2: winner = (prev_winner < n_classes) ? prev_winner : 0;
        3, 4:    winner = 0;
        default: winner = $urandom_range(0, n_classes - 1);
      endcase
      style = $urandom_range(0, 3);
      for (int c = 0; c < n_classes && !done; c++) begin
        case (style)
          0:       s = $urandom_range(0, 65535);        // full range, every bit toggles
          1:       s = $urandom_range(0, 2) - 1;        // narrow range, ties are common
          default: s = (c == winner) ? $urandom_range(0, 32767)
                                     : $urandom_range(0, 32767) - 32768;
        endcase
        row_end = (c == n_classes - 1);
        seq_end = row_end && (f == n_frames - 1);
        if (noisy && seq_end && $urandom_range(0, 1) == 0) row_end = 1'b0;
        if (noisy && f == n_frames - 1 && !row_end && !seq_end &&
            $urandom_range(0, 5) == 0) seq_end = 1'b1;
        push_score(s, row_end, seq_end);
        if (seq_end) done = 1'b1;
      end
      prev_winner = winner;
    end
  endtask

  // ------------------------------------------------------------------------
  // Mismatch reporting
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // ------------------------------------------------------------------------
  // Driver: offer queued scores in bursts with random gaps. Hold the payload steady until
  // the transfer, and pause before a score marked to wait for the results to drain.
  // ------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    score_item_t nxt;
    logic        offering;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        decode_score(in_score, in_row_end, in_sequence_end);
        scores_taken <= scores_taken + 1;
        offering = 1'b0;
      end
      if (!offering) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 48);
          // About a third of the bursts follow straight on, with no gap.
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (score_queue.size() != 0 &&
                     !(score_queue[0].hold_for_drain && decoded_results.size() != 0)) begin
          nxt = score_queue.pop_front();
          in_score        <= nxt.score;
          in_row_end      <= nxt.row_end;
          in_sequence_end <= nxt.seq_end;
          offering = 1'b1;
          burst_left--;
        end
      end
      in_valid <= offering;
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: switch between open, choppy and slow stretches. Once enough scores have
  // gone in, hold off for a long stretch so that the result queue backs up. Rare random
  // hold-offs can also come at any point of the run.
  // ------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_seg_left = 0;
  int       rx_hold_left = 0;
  bit       rx_long_hold_done = 1'b0;

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_seg_left == 0) begin
        if ((!rx_long_hold_done && scores_taken >= 60) || $urandom_range(0, 149) == 0) begin
          rx_long_hold_done = 1'b1;
          rx_hold_left = $urandom_range(150, 260);
        end
        rx_mode     = rx_mode_t'($urandom_range(0, 2));
        rx_seg_left = $urandom_range(1, 30);
      end
      rx_seg_left--;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= ($urandom_range(0, 1) == 1);
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: check each output transfer against the oldest expected result.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_results.size() == 0) begin
        report_mismatch("result with nothing expected, kind", out_kind, 0);
      end else begin
        want = decoded_results.pop_front();
        if (out_kind != want.kind)
          report_mismatch("kind", out_kind, want.kind);
        if (out_char_index != want.char_index)
          report_mismatch("char_index", out_char_index, want.char_index);
        if (out_span_frames != want.span_frames)
          report_mismatch("span_frames", out_span_frames, want.span_frames);
        if (out_last != want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence: build all stimulus, release reset, then wait for the block to drain.
  // ------------------------------------------------------------------------
  initial begin : main_flow
    int unsigned random_base;

    // Sequence of one score, the most negative one: a single blank frame.
    push_score(-32768, 1'b1, 1'b1);

    // Extremes and ties. Class 0 at the top is blank. Equal maxima resolve to the lower
    // class. A repeat is dropped. A new class closes the open span.
    push_score(32767, 1'b0, 1'b0);
    push_score(-32768, 1'b1, 1'b0);
    push_score(-32768, 1'b0, 1'b0);
    push_score(32767, 1'b0, 1'b0);
    push_score(32767, 1'b1, 1'b0);
    push_score(0, 1'b0, 1'b0);
    push_score(5, 1'b0, 1'b0);
    push_score(5, 1'b1, 1'b0);
    push_score(0, 1'b0, 1'b0);
    push_score(-1, 1'b0, 1'b0);
    push_score(7, 1'b1, 1'b0);
    push_score(3, 1'b1, 1'b0);
    push_score(-5, 1'b0, 1'b0);
    push_score(9, 1'b1, 1'b1);

    // Sequence end without row end still closes the frame.
    push_score(1, 1'b0, 1'b0);
    push_score(9, 1'b0, 1'b1);

    // A blank between two equal winners lets the second one through.
    push_score(0, 1'b0, 1'b0);
    push_score(9, 1'b1, 1'b0);
    push_score(9, 1'b0, 1'b0);
    push_score(0, 1'b1, 1'b0);
    push_score(0, 1'b0, 1'b0);
    push_score(9, 1'b1, 1'b1);

    // Random part: mostly well-formed sequences, about a quarter of them broken.
    drain_before_next = 1'b1;
    random_base = score_queue.size();
    while (score_queue.size() < random_base + RANDOM_ITEMS) begin
      if (score_queue.size() > random_base + RANDOM_ITEMS / 2 && !drain_before_next &&
          $urandom_range(0, 15) == 0)
        drain_before_next = 1'b1;
      push_random_sequence($urandom_range(0, 3) == 0);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every score has been transferred and every result has come out.
    // Sample between edges so the driver's updates have settled.
    while (score_queue.size() != 0 || in_valid || decoded_results.size() != 0)
      @(negedge clk);
    // Allow time for any stray result to show up.
    repeat (32) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, set far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
